/* rtl/core/u8u16_pkg.sv */
// ----------------------------------------------------------------------------
// u8u16_pkg
// Shared constants and the code unit burst type of the UTF-8 to UTF-16
// transcoder.
// ----------------------------------------------------------------------------
package u8u16_pkg;

    localparam int unsigned MAX_UNITS = 4;

    localparam logic [15:0] REPLACEMENT_CHAR   = 16'hFFFD;
    localparam logic [20:0] MAX_CODE_POINT     = 21'h10FFFF;
    localparam logic [20:0] SURR_LOW_BOUND     = 21'h00D800;
    localparam logic [20:0] SURR_HIGH_BOUND    = 21'h00DFFF;
    localparam logic [15:0] HIGH_SURR_BASE     = 16'hD800;
    localparam logic [15:0] LOW_SURR_BASE      = 16'hDC00;
    localparam logic [20:0] SUPPLEMENTARY_BASE = 21'h010000;

    // All code units that one input byte produces, first unit in slot zero.
    typedef struct packed {
        logic [2:0]                 count;
        logic [MAX_UNITS-1:0][15:0] units;
    } burst_t;

endpackage

/* rtl/core/utf8_to_utf16_transcoder.sv */
// ----------------------------------------------------------------------------
// utf8_to_utf16_transcoder
// The first code unit of a byte is presented in the cycle after its request
// is accepted. Throughput: one byte per cycle while each byte yields at most
// one code unit and the output does not stall; a byte that yields more units
// (up to four) holds off the input until its final unit is handed out, as the
// result register serializes one unit per unstalled cycle. Reset clears the
// pending sequence and empties the result register; no clearing pass is needed.
// ----------------------------------------------------------------------------
module utf8_to_utf16_transcoder (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        last_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] code_unit,
    output logic        last_of_run
);
    import u8u16_pkg::*;

    burst_t burst;
    logic   seq_pending;
    logic   can_load;
    logic   in_accept;

    // A new request is taken whenever the result register is empty or is
    // handing out its final unit in this very cycle, so bytes that give one
    // unit each stream through at full rate while the output does not stall.
    assign in_stall  = !can_load;
    assign in_accept = in_valid && can_load;

    // The decoder keeps the partial code point and the count of continuation
    // bytes. All the decoding, the range checks and the surrogate split are
    // done combinationally from the incoming byte and that state.
    u8u16_decoder u_decoder (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (in_accept),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .burst       (burst),
        .seq_pending (seq_pending)
    );

    // The emitter registers the whole burst and walks through it.
    u8u16_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (in_accept),
        .burst       (burst),
        .can_load    (can_load),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_unit   (code_unit),
        .last_of_run (last_of_run)
    );

`ifndef SYNTHESIS
    // The input is held off only while units of an earlier byte remain.
    a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> out_valid)
        else $error("input stalled with an empty result register");

    // A unit that is not the last of its burst is always followed by more.
    a_burst_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_of_run) |=> out_valid)
        else $error("burst ended before its last unit");

    // An ASCII byte with no pending sequence passes straight through.
    a_ascii_passthrough: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !seq_pending && !data_byte[7]) |=>
        (out_valid && last_of_run && (code_unit == {8'h00, $past(data_byte)})))
        else $error("ASCII byte not passed through");
`endif

endmodule

/* rtl/core/u8u16_decoder.sv */
// ----------------------------------------------------------------------------
// u8u16_decoder
// Holds the pending sequence state and turns each accepted byte into a
// burst of zero to four UTF-16 code units.
// ----------------------------------------------------------------------------
module u8u16_decoder (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_accept,
    input  logic [7:0]        data_byte,
    input  logic              last_byte,
    output u8u16_pkg::burst_t burst,
    output logic              seq_pending
);
    import u8u16_pkg::*;

    logic [1:0]  expected_reg;
    logic [1:0]  expected_next;
    logic [1:0]  seen_reg;
    logic [1:0]  seen_next;
    logic [20:0] acc_reg;
    logic [20:0] acc_next;

    // Decode of the byte as if no sequence were pending.
    logic        fresh_cnt;
    logic [15:0] fresh_unit;
    logic        fresh_start;
    logic [1:0]  fresh_need;
    logic [4:0]  fresh_bits;

    // Continuation path.
    logic [20:0] acc_cont;
    logic [2:0]  seen_cont;
    logic        completes;
    logic        cp_bad;
    logic [20:0] cp_off;
    logic [15:0] cp_unit0;
    logic [15:0] cp_unit1;
    logic [1:0]  cp_cnt;

    // Burst assembly: a run of replacement units, then up to two tail units.
    logic [2:0]  repl_cnt;
    logic [1:0]  tail_cnt;
    logic [15:0] tail0;
    logic [15:0] tail1;

    assign seq_pending = (expected_reg != 2'd0);

    always_comb
    begin
        fresh_cnt   = 1'b1;
        fresh_unit  = REPLACEMENT_CHAR;
        fresh_start = 1'b0;
        fresh_need  = 2'd0;
        fresh_bits  = 5'd0;
        if (!data_byte[7])
        begin
            fresh_unit = {8'h00, data_byte};
        end
        else if (data_byte[7:5] == 3'b110)
        begin
            fresh_need = 2'd1;
            fresh_bits = data_byte[4:0];
        end
        else if (data_byte[7:4] == 4'b1110)
        begin
            fresh_need = 2'd2;
            fresh_bits = {1'b0, data_byte[3:0]};
        end
        else if (data_byte[7:3] == 5'b11110)
        begin
            fresh_need = 2'd3;
            fresh_bits = {2'b00, data_byte[2:0]};
        end
        // A multi-byte lead flagged last yields one replacement unit.
        if (fresh_need != 2'd0)
        begin
            fresh_cnt   = last_byte;
            fresh_start = !last_byte;
        end
    end

    always_comb
    begin
        acc_cont  = {acc_reg[14:0], data_byte[5:0]};
        seen_cont = {1'b0, seen_reg} + 3'd1;
        completes = (seen_cont >= {1'b0, expected_reg});
        cp_bad    = (acc_cont > MAX_CODE_POINT) ||
                    ((acc_cont >= SURR_LOW_BOUND) && (acc_cont <= SURR_HIGH_BOUND));
        cp_off    = acc_cont - SUPPLEMENTARY_BASE;
        cp_unit1  = LOW_SURR_BASE + {6'd0, cp_off[9:0]};
        if (cp_bad)
        begin
            cp_cnt   = 2'd1;
            cp_unit0 = REPLACEMENT_CHAR;
        end
        else if (acc_cont < SUPPLEMENTARY_BASE)
        begin
            cp_cnt   = 2'd1;
            cp_unit0 = acc_cont[15:0];
        end
        else
        begin
            cp_cnt   = 2'd2;
            cp_unit0 = HIGH_SURR_BASE + {6'd0, cp_off[19:10]};
        end
    end

    always_comb
    begin
        repl_cnt      = 3'd0;
        tail_cnt      = {1'b0, fresh_cnt};
        tail0         = fresh_unit;
        tail1         = cp_unit1;
        expected_next = fresh_start ? fresh_need : 2'd0;
        seen_next     = 2'd0;
        acc_next      = fresh_start ? {16'd0, fresh_bits} : 21'd0;
        if (expected_reg != 2'd0)
        begin
            if (data_byte[7:6] == 2'b10)
            begin
                expected_next = 2'd0;
                acc_next      = 21'd0;
                if (completes)
                begin
                    tail_cnt = cp_cnt;
                    tail0    = cp_unit0;
                end
                else if (last_byte)
                begin
                    // String ends mid-sequence: lead plus every byte seen.
                    repl_cnt = seen_cont + 3'd1;
                    tail_cnt = 2'd0;
                end
                else
                begin
                    tail_cnt      = 2'd0;
                    expected_next = expected_reg;
                    seen_next     = seen_cont[1:0];
                    acc_next      = acc_cont;
                end
            end
            else
            begin
                // Interrupted sequence; the byte itself is decoded afresh.
                repl_cnt = {1'b0, seen_reg} + 3'd1;
            end
        end
    end

    always_comb
    begin
        burst.count = repl_cnt + {1'b0, tail_cnt};
        for (int i = 0; i < MAX_UNITS; i++)
        begin
            if (3'(i) < repl_cnt)
            begin
                burst.units[i] = REPLACEMENT_CHAR;
            end
            else if (3'(i) == repl_cnt)
            begin
                burst.units[i] = tail0;
            end
            else
            begin
                burst.units[i] = tail1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expected_reg <= 2'd0;
            seen_reg     <= 2'd0;
            acc_reg      <= 21'd0;
        end
        else if (in_accept)
        begin
            expected_reg <= expected_next;
            seen_reg     <= seen_next;
            acc_reg      <= acc_next;
        end
    end

endmodule

/* rtl/core/u8u16_emitter.sv */
// ----------------------------------------------------------------------------
// u8u16_emitter
// Result register that holds one burst and hands its code units out one per
// cycle while not stalled, flagging the final unit of the burst.
// ----------------------------------------------------------------------------
module u8u16_emitter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  u8u16_pkg::burst_t burst,
    output logic              can_load,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [15:0]       code_unit,
    output logic              last_of_run
);
    import u8u16_pkg::*;

    logic [2:0]                 remain_reg;
    logic [MAX_UNITS-1:0][15:0] units_reg;
    logic                       take;

    assign out_valid   = (remain_reg != 3'd0);
    assign code_unit   = units_reg[0];
    assign last_of_run = (remain_reg == 3'd1);
    assign take        = out_valid && !out_stall;
    assign can_load    = (remain_reg == 3'd0) || (last_of_run && take);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            remain_reg <= 3'd0;
        end
        else if (load)
        begin
            remain_reg <= burst.count;
        end
        else if (take)
        begin
            remain_reg <= remain_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            units_reg <= burst.units;
        end
        else if (take)
        begin
            for (int i = 0; i < MAX_UNITS - 1; i++)
            begin
                units_reg[i] <= units_reg[i+1];
            end
        end
    end

endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Testbench of the UTF-8 to UTF-16 transcoder. A table of directed bytes
// walks the extremes and the error paths, then random strings follow: mostly
// well-formed characters of one to four bytes with random content, mixed
// with stray bytes and cut-off sequences. Every accepted code unit is checked
// against the answer of a typed table row or else against a behavioral decoder
// kept inside this bench. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8u16_pkg::*;

    localparam int NUM_ROWS      = 27;
    localparam int RANDOM_BYTES  = 320;
    localparam int WATCHDOG_IDLE = 600;
    localparam int SETTLE_CYCLES = 10;

    localparam logic [15:0] RPL   = REPLACEMENT_CHAR;
    localparam logic        TYPED = 1'b1;
    localparam logic        PRED  = 1'b0;

    // One row of the directed table. When typed is set, n and u0..u3 hold the
    // code units that the byte must produce; otherwise the decoder decides.
    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic        typed;
        logic [2:0]  n;
        logic [15:0] u0;
        logic [15:0] u1;
        logic [15:0] u2;
        logic [15:0] u3;
    } stim_row_t;

    typedef struct {
        logic [15:0] unit;
        logic        last;
    } unit_exp_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic        out_valid;
    logic        out_stall;
    logic [15:0] code_unit;
    logic        last_of_run;

    // Decoder state: continuation bytes still owed, bytes seen so far and
    // the code point gathered up to now.
    logic [1:0]  seq_need;
    logic [1:0]  seq_seen;
    logic [20:0] seq_acc;

    // Units that the byte currently being decoded produces.
    logic [15:0] byte_units [MAX_UNITS];
    int          byte_unit_cnt;

    unit_exp_t   expected_units [$];
    int          fail_count;
    int          idle_cycles;
    bit          quiet;

    stim_row_t directed_rows [NUM_ROWS] = '{
        // Extremes of plain ASCII.
        '{8'h00, 1'b0, TYPED, 3'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'h7F, 1'b1, TYPED, 3'd1, 16'h007F, 16'h0000, 16'h0000, 16'h0000},
        // Invalid leads: a stray continuation byte and the 0xF8..0xFF range.
        '{8'h80, 1'b0, TYPED, 3'd1, RPL,      16'h0000, 16'h0000, 16'h0000},
        '{8'hFF, 1'b1, TYPED, 3'd1, RPL,      16'h0000, 16'h0000, 16'h0000},
        '{8'hF8, 1'b0, TYPED, 3'd1, RPL,      16'h0000, 16'h0000, 16'h0000},
        // A multi-byte lead that is also the last byte of its string.
        '{8'hC3, 1'b1, TYPED, 3'd1, RPL,      16'h0000, 16'h0000, 16'h0000},
        // Overlong encoding of NUL is accepted.
        '{8'hC0, 1'b0, TYPED, 3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'h80, 1'b0, TYPED, 3'd1, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        // Code point 0x110000, above the Unicode range.
        '{8'hF4, 1'b0, PRED,  3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'h90, 1'b0, PRED,  3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'h80, 1'b0, PRED,  3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'h80, 1'b0, PRED,  3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        // Encoded surrogate 0xD800.
        '{8'hED, 1'b0, PRED,  3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'hA0, 1'b0, PRED,  3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'h80, 1'b1, PRED,  3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        // The string ends on a continuation byte that does not finish it.
        '{8'hE2, 1'b0, PRED,  3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'h82, 1'b1, TYPED, 3'd2, RPL,      RPL,      16'h0000, 16'h0000},
        // A four-byte sequence broken by an invalid lead: four units at once.
        '{8'hF0, 1'b0, PRED,  3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'h9F, 1'b0, PRED,  3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'h98, 1'b0, PRED,  3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'hFF, 1'b0, TYPED, 3'd4, RPL,      RPL,      RPL,      RPL},
        // A complete supplementary character, giving a surrogate pair.
        '{8'hF0, 1'b0, PRED,  3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'h9F, 1'b0, PRED,  3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'h98, 1'b0, PRED,  3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'h80, 1'b1, PRED,  3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        // A lead interrupted by ASCII, which is then decoded on its own.
        '{8'hC3, 1'b0, PRED,  3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000},
        '{8'h41, 1'b1, PRED,  3'd0, 16'h0000, 16'h0000, 16'h0000, 16'h0000}
    };

    utf8_to_utf16_transcoder u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .data_byte   (data_byte),
        .last_byte   (last_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .code_unit   (code_unit),
        .last_of_run (last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Behavioral decoder
    // ------------------------------------------------------------------------

    function void add_unit(input logic [15:0] u);
        if (byte_unit_cnt < MAX_UNITS)
        begin
            byte_units[byte_unit_cnt] = u;
            byte_unit_cnt++;
        end
    endfunction

    function void drop_sequence();
        seq_need = 2'd0;
        seq_seen = 2'd0;
        seq_acc  = '0;
    endfunction

    // Decodes a byte that arrives with no sequence open. A lead byte opens a
    // sequence unless it is also the last byte of the string.
    function void start_fresh(input logic [7:0] b, input logic l);
        logic [1:0]  need;
        logic [20:0] bits;
        need = 2'd0;
        bits = '0;
        if (b[7] == 1'b0)
            add_unit({8'h00, b});
        else if (b[7:5] == 3'b110)
        begin
            need = 2'd1;
            bits = {16'd0, b[4:0]};
        end
        else if (b[7:4] == 4'b1110)
        begin
            need = 2'd2;
            bits = {17'd0, b[3:0]};
        end
        else if (b[7:3] == 5'b11110)
        begin
            need = 2'd3;
            bits = {18'd0, b[2:0]};
        end
        else
            add_unit(RPL);
        if (need != 2'd0)
        begin
            if (l)
                add_unit(RPL);
            else
            begin
                seq_need = need;
                seq_seen = 2'd0;
                seq_acc  = bits;
            end
        end
    endfunction

    // Works out every code unit that one accepted byte produces, leaving them
    // in byte_units, and advances the decoder state.
    function void transcode_byte(input logic [7:0] b, input logic l);
        logic [20:0] acc;
        logic [20:0] cp;
        logic [20:0] off;
        int          seen;
        int          open_units;
        byte_unit_cnt = 0;
        if (seq_need == 2'd0)
            start_fresh(b, l);
        else if (b[7:6] == 2'b10)
        begin
            acc  = {seq_acc[14:0], b[5:0]};
            seen = int'(seq_seen) + 1;
            if (seen >= int'(seq_need))
            begin
                drop_sequence();
                cp = acc;
                if (cp > MAX_CODE_POINT || (cp >= SURR_LOW_BOUND && cp <= SURR_HIGH_BOUND))
                    cp = {5'd0, RPL};
                if (cp < SUPPLEMENTARY_BASE)
                    add_unit(cp[15:0]);
                else
                begin
                    off = cp - SUPPLEMENTARY_BASE;
                    add_unit(HIGH_SURR_BASE + {6'd0, off[19:10]});
                    add_unit(LOW_SURR_BASE + {6'd0, off[9:0]});
                end
            end
            else if (l)
            begin
                drop_sequence();
                for (int k = 0; k <= seen; k++)
                    add_unit(RPL);
            end
            else
            begin
                seq_acc  = acc;
                seq_seen = seen[1:0];
            end
        end
        else
        begin
            // The lead and each continuation taken so far become U+FFFD.
            open_units = int'(seq_seen);
            drop_sequence();
            for (int k = 0; k <= open_units; k++)
                add_unit(RPL);
            start_fresh(b, l);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Idling
    // ------------------------------------------------------------------------

    // Gap length for either side: usually none, sometimes a few cycles and
    // now and then a long one. While quiet is set nobody idles at all.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (quiet || r < 60)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Quiet stretches come and go on the falling edge, away from the edge at
    // which the drivers read the flag.
    initial
    begin
        quiet = 1'b0;
        forever
        begin
            repeat ($urandom_range(20, 90)) @(negedge clk);
            quiet = ($urandom_range(0, 3) == 0);
        end
    end

    // The receiving side holds off the transcoder for random spells.
    initial
    begin
        int hold;
        out_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            hold = pick_gap();
            if (hold > 0)
            begin
                out_stall <= 1'b1;
                repeat (hold) @(posedge clk);
            end
            out_stall <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Presents one byte and returns at the edge where its request is taken.
    // Valid stays high straight into the next byte when no gap is drawn.
    task automatic send_byte(input logic [7:0] b, input logic l);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        last_byte <= l;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Appends one expected code unit to the scoreboard.
    function void expect_unit(input logic [15:0] u, input logic l);
        unit_exp_t e;
        e.unit = u;
        e.last = l;
        expected_units = {expected_units, e};
    endfunction

    function void queue_decoded();
        for (int i = 0; i < byte_unit_cnt; i++)
            expect_unit(byte_units[i], i == byte_unit_cnt - 1);
    endfunction

    // ------------------------------------------------------------------------
    // Result checking
    // ------------------------------------------------------------------------

    // Outputs are read in the active region of the rising edge, so they
    // still hold the values that the edge samples.
    always @(posedge clk)
    begin
        unit_exp_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_units.size() == 0)
            begin
                $error("code unit %h arrived with nothing expected", code_unit);
                fail_count++;
            end
            else
            begin
                want = expected_units.pop_front();
                if (code_unit !== want.unit)
                begin
                    $error("code_unit: expected %h, got %h", want.unit, code_unit);
                    fail_count++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %b, got %b", want.last, last_of_run);
                    fail_count++;
                end
            end
        end
    end

    // The run is declared hung when neither side moves for too long. The
    // longest legal pause is one long gap or stall drawn by pick_gap.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_IDLE)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------

    initial
    begin
        stim_row_t   row;
        logic [7:0]  str_bytes [$];
        logic [7:0]  lead;
        int          sent;
        int          pick;
        int          len;
        int          keep;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        data_byte   = 8'h00;
        last_byte   = 1'b0;
        fail_count  = 0;
        idle_cycles = 0;
        drop_sequence();
        byte_unit_cnt = 0;

        // Reset is held low and released at a rising edge; the flops still see it
        // low at that edge.
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. Typed rows carry their own answer; the decoder
        // still runs on them so that its state follows the byte stream.
        for (int i = 0; i < NUM_ROWS; i++)
        begin
            row = directed_rows[i];
            send_byte(row.data, row.last);
            transcode_byte(row.data, row.last);
            if (row.typed)
            begin
                if (row.n > 0) expect_unit(row.u0, row.n == 1);
                if (row.n > 1) expect_unit(row.u1, row.n == 2);
                if (row.n > 2) expect_unit(row.u2, row.n == 3);
                if (row.n > 3) expect_unit(row.u3, 1'b1);
            end
            else
                queue_decoded();
        end

        // Random strings. Each string holds a few characters: most are whole
        // sequences of one to four bytes with random payload bits, some are
        // cut short and some are single stray bytes. The final byte of the
        // string carries the last flag, so truncations also land on string
        // ends and on lone leads.
        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            str_bytes.delete();
            repeat ($urandom_range(1, 6))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    str_bytes = {str_bytes, 8'($urandom_range(0, 255))};
                else
                begin
                    len = $urandom_range(1, 4);
                    case (len)
                        1: lead = {1'b0, 7'($urandom_range(0, 127))};
                        2: lead = {3'b110, 5'($urandom_range(0, 31))};
                        3: lead = {4'b1110, 4'($urandom_range(0, 15))};
                        default: lead = {5'b11110, 3'($urandom_range(0, 7))};
                    endcase
                    keep = len;
                    if (len > 1 && pick < 24)
                        keep = $urandom_range(1, len - 1);
                    str_bytes = {str_bytes, lead};
                    for (int k = 1; k < keep; k++)
                        str_bytes = {str_bytes, {2'b10, 6'($urandom_range(0, 63))}};
                end
            end
            foreach (str_bytes[k])
            begin
                send_byte(str_bytes[k], k == str_bytes.size() - 1);
                transcode_byte(str_bytes[k], k == str_bytes.size() - 1);
                queue_decoded();
                sent++;
            end
        end
        in_valid <= 1'b0;

        // Drain: the watchdog bounds this wait. A settling wait then catches any
        // unit that shows up with nothing expected.
        while (expected_units.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
